// File: rtl/core/dcm_pkg.sv
package dcm_pkg;

  // Q16.32 state word and its limits
  localparam int unsigned QW = 48;
  localparam logic signed [QW-1:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 48'sh8000_0000_0000;

  // Multiplier operand b and digit size
  localparam int unsigned BW         = 32;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = BW / DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);

  // Sum width: three 48-bit terms
  localparam int unsigned SW = QW + 2;

  // Register indexes
  localparam logic [2:0] CFG_ARM_RES   = 3'd0;
  localparam logic [2:0] CFG_INV_IND   = 3'd1;
  localparam logic [2:0] CFG_TORQUE_K  = 3'd2;
  localparam logic [2:0] CFG_INV_INERT = 3'd3;
  localparam logic [2:0] CFG_LOAD_TQ   = 3'd4;
  localparam logic [2:0] CFG_VISC_FR   = 3'd5;

  typedef struct packed {
    logic signed [31:0] drive_voltage;
    logic [31:0]        prev_step_len;
    logic [31:0]        step_len;
  } in_beat_t;

  typedef struct packed {
    logic signed [47:0] motor_current;
    logic signed [47:0] shaft_speed;
  } out_beat_t;

  // Multiplier request: sat(trunc(a * b / 2^(sh32 ? 32 : 16)))
  typedef struct packed {
    logic                 start;
    logic                 sh32;
    logic [BW-1:0]        b;
    logic signed [QW-1:0] a;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [QW-1:0] res;
  } mul_rsp_t;

  function automatic logic signed [QW-1:0] sat48(input logic signed [SW-1:0] x);
    logic ovf;
    ovf = (x[SW-1:QW-1] != {(SW-QW+1){1'b0}}) && (x[SW-1:QW-1] != {(SW-QW+1){1'b1}});
    if (!ovf) begin
      return x[QW-1:0];
    end else if (x[SW-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

// File: rtl/core/dcm_mul.sv
module dcm_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcm_pkg::mul_req_t  req_i,
  output dcm_pkg::mul_rsp_t  rsp_o
);
  import dcm_pkg::*;

  localparam int unsigned PW = QW + DIGIT_W;

  logic [QW-1:0]    mag_q;
  logic [BW-1:0]    b_q;
  logic [QW-1:0]    acc_q;
  logic [BW-1:0]    low_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, neg_q, sh32_q;

  logic [QW-1:0]    mag_in;
  logic [PW-1:0]    part;
  logic             big;
  logic [QW-2:0]    r_low;
  logic [QW-1:0]    r_mag;

  assign mag_in = req_i.a[QW-1] ? QW'(-req_i.a) : QW'(req_i.a);
  // one digit of b per cycle, product bits leave LSB first into low_q
  assign part   = PW'(acc_q) + PW'(mag_q) * PW'(b_q[DIGIT_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mag_q  <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      low_q  <= '0;
      neg_q  <= 1'b0;
      sh32_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        mag_q  <= mag_in;
        b_q    <= req_i.b;
        neg_q  <= req_i.a[QW-1];
        sh32_q <= req_i.sh32;
        acc_q  <= '0;
        low_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= part[PW-1:DIGIT_W];
        low_q <= {part[DIGIT_W-1:0], low_q[BW-1:DIGIT_W]};
        b_q   <= b_q >> DIGIT_W;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // product = {acc_q, low_q}; pick the shifted window and its overflow bits
  always_comb begin
    if (sh32_q) begin
      big   = acc_q[QW-1];
      r_low = acc_q[QW-2:0];
    end else begin
      big   = |acc_q[QW-1:QW-17];
      r_low = {acc_q[QW-18:0], low_q[BW-1:16]};
    end
    r_mag = {1'b0, r_low};
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = neg_q ? (big ? Q_MIN : $signed(-r_mag))
                            : (big ? Q_MAX : $signed(r_mag));

endmodule

// File: rtl/core/dc_motor_euler_step_core.sv
// DC motor forward-Euler step core.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat per step with the
// drive voltage, the previous step length and this step's length.
// Output channel (out_valid_o/out_ready_i/out_data_o): one beat per input beat
// carrying winding current and shaft speed after the step, signed Q16.32.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always
// ready; indexes 0..5 select resistance, 1/L, Kt, 1/J, load torque and
// viscous friction; other indexes are dropped. Write only while idle.
// Timing: eight multiplications run in turn on one digit-serial multiplier
// that consumes 4 bits of the 32-bit operand per cycle. A step passes through
// the sequencer states IDLE, RUN and OUT; the result beat is registered in
// OUT, and the next input beat is taken only back in IDLE.
// in_ready_o is high only while the sequencer is idle.
// Stall: the finished step waits for the output register to free up; the
// state is already updated, nothing is lost.
// Reset: config registers go to their defaults; current, slope and speed to 0.
module dc_motor_euler_step_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dcm_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dcm_pkg::out_beat_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import dcm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  // multiplication order within a step
  typedef enum logic [2:0] {
    OP_ADV,    // slope * prev_len, advance current
    OP_RI,     // R * i
    OP_KW,     // Kt * w, form v - Ri - Kw
    OP_SLOPE,  // sum * 1/L
    OP_KI,     // Kt * i
    OP_BW,     // B * w, form torque
    OP_ACCEL,  // torque * 1/J
    OP_SPEED   // accel * len, advance speed
  } op_e;

  state_e state_q;
  op_e    op_q;
  logic   start_q;

  logic [30:0]        arm_res_q, inv_ind_q, torque_k_q, inv_inert_q, visc_fr_q;
  logic signed [31:0] load_tq_q;

  logic signed [31:0] volt_q;
  logic [31:0]        prev_len_q, len_q;

  logic signed [QW-1:0] cur_q, slope_q, spd_q, tmp_q;
  out_beat_t            out_q;
  logic                 out_valid_q;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic signed [SW-1:0] volt_x, load_x, res_x, cur_x, spd_x, tmp_x;

  assign volt_x = {{2{volt_q[31]}}, volt_q, 16'b0};
  assign load_x = {{2{load_tq_q[31]}}, load_tq_q, 16'b0};
  assign res_x  = {{2{mrsp.res[QW-1]}}, mrsp.res};
  assign cur_x  = {{2{cur_q[QW-1]}}, cur_q};
  assign spd_x  = {{2{spd_q[QW-1]}}, spd_q};
  assign tmp_x  = {{2{tmp_q[QW-1]}}, tmp_q};

  always_comb begin
    mreq.start = start_q;
    mreq.sh32  = 1'b0;
    mreq.a     = tmp_q;
    mreq.b     = '0;
    unique case (op_q)
      OP_ADV: begin
        mreq.a    = slope_q;
        mreq.b    = prev_len_q;
        mreq.sh32 = 1'b1;
      end
      OP_RI: begin
        mreq.a = cur_q;
        mreq.b = {1'b0, arm_res_q};
      end
      OP_KW: begin
        mreq.a = spd_q;
        mreq.b = {1'b0, torque_k_q};
      end
      OP_SLOPE: begin
        mreq.b = {1'b0, inv_ind_q};
      end
      OP_KI: begin
        mreq.a = cur_q;
        mreq.b = {1'b0, torque_k_q};
      end
      OP_BW: begin
        mreq.a = spd_q;
        mreq.b = {1'b0, visc_fr_q};
      end
      OP_ACCEL: begin
        mreq.b = {1'b0, inv_inert_q};
      end
      OP_SPEED: begin
        mreq.b    = len_q;
        mreq.sh32 = 1'b1;
      end
      default: begin
        mreq.b = '0;
      end
    endcase
  end

  dcm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_ADV;
      start_q     <= 1'b0;
      arm_res_q   <= 31'd32768;
      inv_ind_q   <= 31'd43690667;
      torque_k_q  <= 31'd3277;
      inv_inert_q <= 31'd262144000;
      load_tq_q   <= '0;
      visc_fr_q   <= '0;
      volt_q      <= '0;
      prev_len_q  <= '0;
      len_q       <= '0;
      cur_q       <= '0;
      slope_q     <= '0;
      spd_q       <= '0;
      tmp_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= 1'b0;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ARM_RES:   arm_res_q   <= cfg_data_i[30:0];
          CFG_INV_IND:   inv_ind_q   <= cfg_data_i[30:0];
          CFG_TORQUE_K:  torque_k_q  <= cfg_data_i[30:0];
          CFG_INV_INERT: inv_inert_q <= cfg_data_i[30:0];
          CFG_LOAD_TQ:   load_tq_q   <= cfg_data_i;
          CFG_VISC_FR:   visc_fr_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            volt_q     <= in_data_i.drive_voltage;
            prev_len_q <= in_data_i.prev_step_len;
            len_q      <= in_data_i.step_len;
            op_q       <= OP_ADV;
            start_q    <= 1'b1;
            state_q    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (mrsp.done) begin
            unique case (op_q)
              OP_ADV:   cur_q   <= sat48(cur_x + res_x);
              OP_RI:    tmp_q   <= mrsp.res;
              OP_KW:    tmp_q   <= sat48(volt_x - tmp_x - res_x);
              OP_SLOPE: slope_q <= mrsp.res;
              OP_KI:    tmp_q   <= mrsp.res;
              OP_BW:    tmp_q   <= sat48(tmp_x - res_x - load_x);
              OP_ACCEL: tmp_q   <= mrsp.res;
              OP_SPEED: spd_q   <= sat48(spd_x + res_x);
              default: ;
            endcase
            if (op_q == OP_SPEED) begin
              state_q <= ST_OUT;
            end else begin
              op_q    <= op_e'(op_q + 3'd1);
              start_q <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.motor_current <= cur_q;
            out_q.shaft_speed   <= spd_q;
            out_valid_q         <= 1'b1;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule
